@@ hw/rtl/sapq_pkg.sv @@
// shared types and codes for the sorted array priority queue
package sapq_pkg;

	// stream payload widths
	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned S_TDATA_W = 32;
	localparam int unsigned M_TDATA_W = 40;
	localparam int unsigned M_PAD_W   = M_TDATA_W - VALUE_W - 2;

	// request kinds carried on s_tuser
	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_DEQ = 1'b1;

	// result status carried on m_tuser
	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_OVERFLOW  = 2'd1,
		STATUS_UNDERFLOW = 2'd2
	} status_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_INS  = 4'b0010,
		ST_DEQ  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic    ld_req;       // capture value at input transfer
		logic    ld_pos;       // insertion slot starts at the tail
		logic    dec_pos;      // move insertion slot one toward the head
		logic    rd_head;      // read the head entry
		logic    rd_next;      // read the entry below the next slot
		logic    mem_we;       // write the slot
		logic    wsel_val;     // write the new value, else the shifted entry
		logic    count_inc;
		logic    count_dec;
		logic    head_inc;
		logic    set_res;      // load the pending result
		status_t res_code;
		logic    res_rdata;    // pending result data comes from the read port
		logic    out_load;     // move pending result to the output register
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic full;
		logic empty;
		logic pos_zero;
		logic rd_gt_val;       // entry read is greater than the new value
		logic out_free;
	} stat_t;

endpackage

@@ hw/rtl/sapq_ctrl.sv @@
// sequencing controller for the sorted array priority queue
module sapq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic           in_deq,
	input  sapq_pkg::stat_t stat,
	output sapq_pkg::cmd_t  cmd
);

	sapq_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sapq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == sapq_pkg::ST_IDLE);

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.res_code = sapq_pkg::STATUS_OK;
		unique case (state_q)
			sapq_pkg::ST_IDLE: begin
				cmd.rd_head = in_deq;
				if (s_tvalid) begin
					cmd.ld_req = 1'b1;
					if (!in_deq) begin
						if (stat.full) begin
							cmd.set_res  = 1'b1;
							cmd.res_code = sapq_pkg::STATUS_OVERFLOW;
							state_d      = sapq_pkg::ST_DONE;
						end else begin
							cmd.ld_pos = 1'b1;
							state_d    = sapq_pkg::ST_INS;
						end
					end else begin
						if (stat.empty) begin
							cmd.set_res  = 1'b1;
							cmd.res_code = sapq_pkg::STATUS_UNDERFLOW;
							state_d      = sapq_pkg::ST_DONE;
						end else begin
							state_d = sapq_pkg::ST_DEQ;
						end
					end
				end
			end
			sapq_pkg::ST_INS: begin
				cmd.mem_we = 1'b1;
				if (stat.pos_zero || !stat.rd_gt_val) begin
					// slot found: drop the new value in
					cmd.wsel_val  = 1'b1;
					cmd.count_inc = 1'b1;
					cmd.set_res   = 1'b1;
					state_d       = sapq_pkg::ST_DONE;
				end else begin
					// shift the larger entry up one slot
					cmd.dec_pos = 1'b1;
					cmd.rd_next = 1'b1;
				end
			end
			sapq_pkg::ST_DEQ: begin
				cmd.set_res   = 1'b1;
				cmd.res_rdata = 1'b1;
				cmd.head_inc  = 1'b1;
				cmd.count_dec = 1'b1;
				state_d       = sapq_pkg::ST_DONE;
			end
			sapq_pkg::ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = sapq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sapq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/sapq_datapath.sv @@
// entry memory, pointers and result registers of the sorted array priority queue
module sapq_datapath #(
	parameter int unsigned DEPTH = 128
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic signed [sapq_pkg::VALUE_W-1:0] in_value,
	input  sapq_pkg::cmd_t                      cmd,
	output sapq_pkg::stat_t                     stat,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [sapq_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic [1:0]                         m_tuser
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
	localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);

	logic signed [sapq_pkg::VALUE_W-1:0] mem [DEPTH];
	logic signed [sapq_pkg::VALUE_W-1:0] rdata_q, val_q, res_data_q, wdata;
	logic [AW-1:0] head_q, pos_q, rd_off, tail_off, next_off, raddr, waddr;
	logic [CW-1:0] count_q;
	sapq_pkg::status_t res_status_q;
	logic m_tvalid_q;
	logic [sapq_pkg::M_TDATA_W-1:0] m_tdata_q;
	logic [1:0] m_tuser_q;

	// circular address: head plus offset, modulo depth
	function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [AW-1:0] off);
		logic [AW:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= DEPTH_W) begin
			s = s - DEPTH_W;
		end
		return s[AW-1:0];
	endfunction

	// read offset selection
	always_comb begin
		tail_off = (count_q == '0) ? '0 : AW'(count_q - CW'(1));
		next_off = (pos_q >= AW'(2)) ? AW'(pos_q - AW'(2)) : '0;
		if (cmd.rd_next) begin
			rd_off = next_off;
		end else if (cmd.rd_head) begin
			rd_off = '0;
		end else begin
			rd_off = tail_off;
		end
	end

	assign raddr = wrap(head_q, rd_off);
	assign waddr = wrap(head_q, pos_q);
	assign wdata = cmd.wsel_val ? val_q : rdata_q;

	// entry memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (cmd.ld_req) begin
			val_q <= in_value;
		end
		if (cmd.ld_pos) begin
			pos_q <= AW'(count_q);
		end else if (cmd.dec_pos) begin
			pos_q <= pos_q - AW'(1);
		end
		if (cmd.set_res) begin
			res_status_q <= cmd.res_code;
			res_data_q   <= cmd.res_rdata ? rdata_q : '0;
		end
		if (cmd.out_load) begin
			m_tdata_q <= {{sapq_pkg::M_PAD_W{1'b0}}, stat.empty, stat.full, res_data_q};
			m_tuser_q <= res_status_q;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.head_inc) begin
				head_q <= (head_q == LAST_A) ? '0 : head_q + AW'(1);
			end
			if (cmd.count_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.count_dec) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// status toward the controller
	assign stat.full      = (count_q == FULL_C);
	assign stat.empty     = (count_q == '0);
	assign stat.pos_zero  = (pos_q == '0);
	assign stat.rd_gt_val = (rdata_q > val_q);
	assign stat.out_free  = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

@@ hw/rtl/sorted_array_priority_queue_unit.sv @@
// Min-priority queue of up to DEPTH signed 32-bit values, held in ascending order in a
// circular memory with one write and one registered read port. A dequeue reads the head
// entry through the registered port and loads it as the result; an enqueue walks from
// the tail toward the head, moving one larger entry up per cycle, until it passes every
// stored entry greater than the new value (equal values stay ahead of it). An overflow
// or underflow result is set directly from the full or empty flag. One request is in
// work at a time; s_tready returns high as the result enters the output register, which
// holds it until taken. The memory needs no clearing after reset.
module sorted_array_priority_queue_unit #(
	parameter int unsigned DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic        s_tuser,   // [0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] data, [32] is_full, [33] is_empty, rest zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	sapq_pkg::cmd_t  cmd;
	sapq_pkg::stat_t stat;

	sapq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.in_deq   (s_tuser == sapq_pkg::REQ_DEQ),
		.stat     (stat),
		.cmd      (cmd)
	);

	sapq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_value ($signed(s_tdata)),
		.cmd      (cmd),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
